@@ src/spn_pkg.sv @@
// ----------------------------------------------------------------------------
// spn_pkg
// Shared types, S-box table and round functions of the 32-bit SPN cipher.
// ----------------------------------------------------------------------------
package spn_pkg;

  localparam int unsigned BLOCK_W      = 32;
  localparam int unsigned KEY_ROT_STEP = 11;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [4:0]         rot_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic block_t spn_rotl(input block_t v, input rot_t s);
    logic [2*BLOCK_W-1:0] both;
    both = {v, v} << s;
    return both[2*BLOCK_W-1:BLOCK_W];
  endfunction

  function automatic block_t spn_substitute(input block_t v);
    block_t res;
    for (int n = 0; n < 8; n++) begin
      res[4*n +: 4] = SBOX[v[4*n +: 4]];
    end
    return res;
  endfunction

  // Output position 8a+b takes input position 4b+a; position p is bit 31-p.
  function automatic block_t spn_transpose(input block_t v);
    block_t res;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 8; b++) begin
        res[31-(8*a+b)] = v[31-(4*b+a)];
      end
    end
    return res;
  endfunction

endpackage

@@ src/spn_round_cell.sv @@
// ----------------------------------------------------------------------------
// spn_round_cell
// One round of the cipher with its own beat register: key mix, S-box layer,
// then either the bit transpose or, in the last round, the final key mix.
// ----------------------------------------------------------------------------
module spn_round_cell #(
  parameter int unsigned ROUND_IDX = 1,
  parameter bit          IS_LAST   = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spn_pkg::block_t key_i,
  input  logic            valid_i,
  input  spn_pkg::block_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output spn_pkg::block_t data_o,
  input  logic            ready_i
);
  import spn_pkg::*;

  localparam rot_t ROT_CUR = rot_t'((KEY_ROT_STEP * ROUND_IDX) % 32);

  block_t mixed;
  block_t subst;
  block_t result_d;
  block_t data_q;
  logic   valid_q;

  assign mixed = data_i ^ spn_rotl(key_i, ROT_CUR);
  assign subst = spn_substitute(mixed);

  generate
    if (IS_LAST) begin : g_last
      localparam rot_t ROT_NEXT = rot_t'((KEY_ROT_STEP * (ROUND_IDX + 1)) % 32);
      assign result_d = subst ^ spn_rotl(key_i, ROT_NEXT);
    end else begin : g_mid
      assign result_d = spn_transpose(subst);
    end
  endgenerate

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= result_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/spn_cipher_32bit_encrypt.sv @@
// ----------------------------------------------------------------------------
// spn_cipher_32bit_encrypt
// Each round cell registers its result; a block passes through every round cell in turn.
// Throughput: one block per cycle while the output is not stalled; each round cell holds one beat.
// A stalled output backs up the cell chain; ready passes back through full cells combinationally.
// Reset clears all valid flags and sets the key register to zero.
// ----------------------------------------------------------------------------
module spn_cipher_32bit_encrypt #(
  parameter int unsigned ROUND_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cipher_key_we_i,
  input  spn_pkg::block_t cipher_key_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  spn_pkg::block_t plaintext_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spn_pkg::block_t ciphertext_o
);
  import spn_pkg::*;

  block_t key_q;
  logic   valid_w [ROUND_COUNT+1];
  logic   ready_w [ROUND_COUNT+1];
  block_t data_w  [ROUND_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cipher_key_we_i) begin
      key_q <= cipher_key_i;
    end
  end

  assign valid_w[0] = in_valid_i;
  assign data_w[0]  = plaintext_i;
  assign in_ready_o = ready_w[0];

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_cell
    spn_round_cell #(
      .ROUND_IDX (r + 1),
      .IS_LAST   (r == ROUND_COUNT - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .valid_i (valid_w[r]),
      .data_i  (data_w[r]),
      .ready_o (ready_w[r]),
      .valid_o (valid_w[r+1]),
      .data_o  (data_w[r+1]),
      .ready_i (ready_w[r+1])
    );
  end

  assign ready_w[ROUND_COUNT] = out_ready_i;
  assign out_valid_o          = valid_w[ROUND_COUNT];
  assign ciphertext_o         = data_w[ROUND_COUNT];

endmodule

@@ src/spn_checker.sv @@
// ----------------------------------------------------------------------------
// spn_checker
// Port-level checks of the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module spn_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input spn_pkg::block_t ciphertext_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(ciphertext_o))
    else $error("stalled output beat changed");

  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind spn_cipher_32bit_encrypt spn_checker u_spn_checker (.*);
